// ===== rtl/core/earom_group_update_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Storage group update sequencer: assertion macros
// Concurrent check macros sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EAROM_GROUP_UPDATE_SEQUENCER_ASSERT_SVH
`define EAROM_GROUP_UPDATE_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define EUS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");
// next-cycle implication
`define EUS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");
`else
`define EUS_ASSERT_IMPLY(lbl, ante, cons)
`define EUS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/eus_pkg.sv =====
// ----------------------------------------------------------------------------
// Storage group update sequencer package
// Shared constants, operation and phase codes, controller command types.
// ----------------------------------------------------------------------------
`default_nettype none

package eus_pkg;

    // defaults for the top level parameters
    localparam int EUS_GROUP_COUNT     = 3;
    localparam int EUS_MAX_GROUP_BYTES = 63;

    // fixed widths of the register file and item fields
    localparam int LAYOUT_COUNT = 3;
    localparam int LAYOUT_IDX_W = 2;
    localparam int LAYOUT_W     = 32;
    localparam int MASK_W       = 3;
    localparam int RAM_ADDR_W   = 16;
    localparam int BYTE_W       = 8;
    localparam int CTL_W        = 4;

    // storage control codes: bit0 enable, bit1 write, bit2 erase, bit3 clock
    localparam logic [CTL_W-1:0] CTL_NONE  = 4'h0;
    localparam logic [CTL_W-1:0] CTL_ERASE = 4'h7;
    localparam logic [CTL_W-1:0] CTL_WRITE = 4'h3;
    localparam logic [CTL_W-1:0] CTL_READ  = 4'h9;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_ZERO     = 2'd1,
        OP_READ_ALL = 2'd2,
        OP_STEP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ERASE = 2'd1,
        PH_WRITE = 2'd2,
        PH_READ  = 2'd3
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic select;
        logic exec;
        logic clear_next;
    } eus_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_res;
    } eus_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/earom_group_update_sequencer.sv =====
// ----------------------------------------------------------------------------
// Storage group update sequencer
// Serves write, zero and read-all requests for GROUP_COUNT storage groups,
// one storage byte per step item, with checksum generation and checking.
// ----------------------------------------------------------------------------
// An item passes through accept, group select, execute and result, and
// its result waits while out_stall is high; one item is in the block at a
// time, so a new item is taken only once the final result of the previous
// one has gone. A read step that ends in a checksum mismatch delivers one
// further result per cleared RAM byte from the controller's result state.
// next_ram_addr, busy_res and bad_groups show the state after the item and
// hold while its results are delivered; ram_byte of a step item must be the
// RAM byte at the next_ram_addr of the previous result.
`default_nettype none

`include "earom_group_update_sequencer_assert.svh"

module earom_group_update_sequencer
    import eus_pkg::*;
#(
    parameter int GROUP_COUNT     = EUS_GROUP_COUNT,
    parameter int MAX_GROUP_BYTES = EUS_MAX_GROUP_BYTES
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [LAYOUT_IDX_W-1:0]  cfg_index,
    input  wire logic [LAYOUT_W-1:0]      cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               op,
    input  wire logic [MASK_W-1:0]        group_mask,
    input  wire logic [BYTE_W-1:0]        ram_byte,
    input  wire logic [BYTE_W-1:0]        storage_byte,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [BYTE_W-1:0]             storage_addr,
    output logic [BYTE_W-1:0]             storage_data,
    output logic [CTL_W-1:0]              storage_ctl,
    output logic [RAM_ADDR_W-1:0]         ram_addr,
    output logic [BYTE_W-1:0]             ram_data,
    output logic                          ram_write,
    output logic [RAM_ADDR_W-1:0]         next_ram_addr,
    output logic                          busy_res,
    output logic [MASK_W-1:0]             bad_groups,
    output logic                          last
);

    eus_cmd_t    cmd;
    eus_status_t status;

    // sequence control
    eus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // transfer state and results
    eus_datapath #(
        .GROUP_COUNT     (GROUP_COUNT),
        .MAX_GROUP_BYTES (MAX_GROUP_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .group_mask    (group_mask),
        .ram_byte      (ram_byte),
        .storage_byte  (storage_byte),
        .storage_addr  (storage_addr),
        .storage_data  (storage_data),
        .storage_ctl   (storage_ctl),
        .ram_addr      (ram_addr),
        .ram_data      (ram_data),
        .ram_write     (ram_write),
        .next_ram_addr (next_ram_addr),
        .busy_res      (busy_res),
        .bad_groups    (bad_groups),
        .last          (last)
    );

    // checks
    `EUS_ASSERT_IMPLY(a_one_item_at_a_time, in_valid && !in_stall, !out_valid)
    `EUS_ASSERT_NEXT(a_last_ends_item, out_valid && !out_stall && last, !out_valid)
    `EUS_ASSERT_NEXT(a_clear_follows, out_valid && !out_stall && !last, out_valid && ram_write)
    `EUS_ASSERT_NEXT(a_bad_sticky, 1'b1, (bad_groups & $past(bad_groups)) == $past(bad_groups))

endmodule

`default_nettype wire

// ===== rtl/core/eus_ctrl.sv =====
// ----------------------------------------------------------------------------
// Storage group update sequencer controller
// Walks each item through accept, group select, execute and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module eus_ctrl
    import eus_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire eus_status_t status,
    output eus_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEL  = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall && status.last_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // handshakes and datapath commands
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign cmd.accept     = (state_reg == S_IDLE) && in_valid;
    assign cmd.select     = (state_reg == S_SEL);
    assign cmd.exec       = (state_reg == S_EXEC);
    assign cmd.clear_next = (state_reg == S_OUT) && !out_stall && !status.last_res;

endmodule

`default_nettype wire

// ===== rtl/core/eus_datapath.sv =====
// ----------------------------------------------------------------------------
// Storage group update sequencer datapath
// Layout registers, group transfer state, checksum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eus_datapath
    import eus_pkg::*;
#(
    parameter int GROUP_COUNT     = EUS_GROUP_COUNT,
    parameter int MAX_GROUP_BYTES = EUS_MAX_GROUP_BYTES
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire eus_cmd_t                 cmd,
    output eus_status_t                   status,
    input  wire logic                     cfg_we,
    input  wire logic [LAYOUT_IDX_W-1:0]  cfg_index,
    input  wire logic [LAYOUT_W-1:0]      cfg_data,
    input  wire logic [1:0]               op,
    input  wire logic [MASK_W-1:0]        group_mask,
    input  wire logic [BYTE_W-1:0]        ram_byte,
    input  wire logic [BYTE_W-1:0]        storage_byte,
    output logic [BYTE_W-1:0]             storage_addr,
    output logic [BYTE_W-1:0]             storage_data,
    output logic [CTL_W-1:0]              storage_ctl,
    output logic [RAM_ADDR_W-1:0]         ram_addr,
    output logic [BYTE_W-1:0]             ram_data,
    output logic                          ram_write,
    output logic [RAM_ADDR_W-1:0]         next_ram_addr,
    output logic                          busy_res,
    output logic [MASK_W-1:0]             bad_groups,
    output logic                          last
);

    localparam int IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int OFS_W = $clog2(MAX_GROUP_BYTES + 1);
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MAX_GROUP_BYTES - 1);

    // layout registers
    logic [LAYOUT_W-1:0]    layout_reg [LAYOUT_COUNT];
    logic [LAYOUT_W-1:0]    layout_next [LAYOUT_COUNT];

    // group transfer state
    logic [GROUP_COUNT-1:0] pend_reg, pend_next;
    logic [GROUP_COUNT-1:0] wr_reg, wr_next;
    logic                   zero_reg, zero_next;
    phase_t                 phase_reg, phase_next;
    logic [GROUP_COUNT-1:0] sel_reg, sel_next;
    logic [BYTE_W-1:0]      ptr_reg, ptr_next;
    logic [BYTE_W-1:0]      chk_reg, chk_next;
    logic [RAM_ADDR_W-1:0]  base_reg, base_next;
    logic [OFS_W-1:0]       ofs_reg, ofs_next;
    logic [BYTE_W-1:0]      sum_reg, sum_next;
    logic [GROUP_COUNT-1:0] bad_reg, bad_next;
    logic [OFS_W-1:0]       clr_reg, clr_next;

    // latched item fields
    op_t                    op_reg, op_next;
    logic [BYTE_W-1:0]      rbyte_reg, rbyte_next;
    logic [BYTE_W-1:0]      sbyte_reg, sbyte_next;

    // result register
    logic [BYTE_W-1:0]      saddr_reg, saddr_next;
    logic [BYTE_W-1:0]      sdata_reg, sdata_next;
    logic [CTL_W-1:0]       sctl_reg, sctl_next;
    logic [RAM_ADDR_W-1:0]  raddr_reg, raddr_next;
    logic [BYTE_W-1:0]      rdata_reg, rdata_next;
    logic                   rwrite_reg, rwrite_next;
    logic                   last_reg, last_next;

    // helpers
    logic [GROUP_COUNT-1:0] mask_g;
    logic [IDX_W-1:0]       sel_idx;
    logic [LAYOUT_W-1:0]    sel_layout;
    logic [RAM_ADDR_W-1:0]  cur_ram_addr;
    logic [RAM_ADDR_W-1:0]  clr_ram_addr;
    logic [OFS_W-1:0]       clr_dec;
    logic                   last_byte;
    logic                   step_op;
    logic [BYTE_W-1:0]      wr_byte;

    // request mask bits beyond the group count are dropped
    for (genvar gi = 0; gi < GROUP_COUNT; gi++)
    begin : g_mask
        if (gi < MASK_W)
        begin : g_in
            assign mask_g[gi] = group_mask[gi];
        end
        else
        begin : g_out
            assign mask_g[gi] = 1'b0;
        end
    end

    // bad flags onto the fixed-width status port
    for (genvar bi = 0; bi < MASK_W; bi++)
    begin : g_bad
        if (bi < GROUP_COUNT)
        begin : g_in
            assign bad_groups[bi] = bad_reg[bi];
        end
        else
        begin : g_out
            assign bad_groups[bi] = 1'b0;
        end
    end

    // highest pending group
    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            if (pend_reg[i])
            begin
                sel_idx = IDX_W'(i);
            end
        end
    end

    // groups without a register use an all-zero layout
    always_comb
    begin
        sel_layout = '0;
        if (int'(sel_idx) < LAYOUT_COUNT)
        begin
            sel_layout = layout_reg[LAYOUT_IDX_W'(sel_idx)];
        end
    end

    assign cur_ram_addr = base_reg + {{(RAM_ADDR_W-OFS_W){1'b0}}, ofs_reg};
    assign clr_dec      = clr_reg - OFS_W'(1);
    assign clr_ram_addr = base_reg + {{(RAM_ADDR_W-OFS_W){1'b0}}, clr_dec};
    assign last_byte    = (ptr_reg >= chk_reg) || (ofs_reg >= OFS_LAST);
    assign step_op      = (op_reg == OP_READ_ALL) || (op_reg == OP_STEP);
    assign wr_byte      = last_byte ? sum_reg : (zero_reg ? '0 : rbyte_reg);

    // next-state logic
    always_comb
    begin
        layout_next = layout_reg;
        pend_next   = pend_reg;
        wr_next     = wr_reg;
        zero_next   = zero_reg;
        phase_next  = phase_reg;
        sel_next    = sel_reg;
        ptr_next    = ptr_reg;
        chk_next    = chk_reg;
        base_next   = base_reg;
        ofs_next    = ofs_reg;
        sum_next    = sum_reg;
        bad_next    = bad_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        rbyte_next  = rbyte_reg;
        sbyte_next  = sbyte_reg;
        saddr_next  = saddr_reg;
        sdata_next  = sdata_reg;
        sctl_next   = sctl_reg;
        raddr_next  = raddr_reg;
        rdata_next  = rdata_reg;
        rwrite_next = rwrite_reg;
        last_next   = last_reg;

        // configuration write; indexes past the list are ignored
        if (cfg_we && (int'(cfg_index) < LAYOUT_COUNT))
        begin
            layout_next[cfg_index] = cfg_data;
        end

        // item accept: latch fields and apply requests
        if (cmd.accept)
        begin
            op_next    = op_t'(op);
            rbyte_next = ram_byte;
            sbyte_next = storage_byte;
            if ((op_t'(op) == OP_WRITE) || (op_t'(op) == OP_ZERO))
            begin
                zero_next = (op_t'(op) == OP_ZERO);
                pend_next = pend_reg | mask_g;
                wr_next   = wr_reg | mask_g;
            end
            else if (op_t'(op) == OP_READ_ALL)
            begin
                pend_next = '1;
                wr_next   = '0;
            end
        end

        // start the highest pending group when no transfer runs
        if (cmd.select && step_op && (phase_reg == PH_IDLE) && (pend_reg != '0))
        begin
            sel_next            = '0;
            sel_next[sel_idx]   = 1'b1;
            ofs_next            = '0;
            sum_next            = '0;
            phase_next          = wr_reg[sel_idx] ? PH_ERASE : PH_READ;
            pend_next           = pend_reg;
            pend_next[sel_idx]  = 1'b0;
            ptr_next            = sel_layout[7:0];
            chk_next            = sel_layout[15:8];
            base_next           = sel_layout[31:16];
        end

        // one storage byte
        if (cmd.exec)
        begin
            saddr_next  = '0;
            sdata_next  = '0;
            sctl_next   = CTL_NONE;
            raddr_next  = '0;
            rdata_next  = '0;
            rwrite_next = 1'b0;
            last_next   = 1'b1;
            if (step_op)
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_ERASE:
                    begin
                        saddr_next = ptr_reg;
                        sctl_next  = CTL_ERASE;
                        phase_next = PH_WRITE;
                    end
                    PH_WRITE:
                    begin
                        saddr_next  = ptr_reg;
                        sdata_next  = wr_byte;
                        sctl_next   = CTL_WRITE;
                        if (zero_reg)
                        begin
                            raddr_next  = cur_ram_addr;
                            rwrite_next = 1'b1;
                        end
                        phase_next = last_byte ? PH_IDLE : PH_ERASE;
                        sum_next   = sum_reg + wr_byte;
                        ofs_next   = ofs_reg + OFS_W'(1);
                        ptr_next   = ptr_reg + 8'd1;
                    end
                    PH_READ:
                    begin
                        saddr_next = ptr_reg;
                        sctl_next  = CTL_READ;
                        if (!last_byte)
                        begin
                            raddr_next  = cur_ram_addr;
                            rdata_next  = sbyte_reg;
                            rwrite_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            // checksum mismatch: clear from this offset down to zero
                            if (sbyte_reg != sum_reg)
                            begin
                                raddr_next  = cur_ram_addr;
                                rwrite_next = 1'b1;
                                clr_next    = ofs_reg;
                                last_next   = (ofs_reg == '0);
                                bad_next    = bad_reg | sel_reg;
                            end
                        end
                        sum_next = sum_reg + sbyte_reg;
                        ofs_next = ofs_reg + OFS_W'(1);
                        ptr_next = ptr_reg + 8'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // next cleared RAM byte after a mismatch
        if (cmd.clear_next)
        begin
            clr_next    = clr_dec;
            saddr_next  = '0;
            sdata_next  = '0;
            sctl_next   = CTL_NONE;
            raddr_next  = clr_ram_addr;
            rdata_next  = '0;
            rwrite_next = 1'b1;
            last_next   = (clr_dec == '0);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYOUT_COUNT; i++)
            begin
                layout_reg[i] <= '0;
            end
            pend_reg  <= '0;
            wr_reg    <= '0;
            zero_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            sel_reg   <= '0;
            ptr_reg   <= '0;
            chk_reg   <= '0;
            base_reg  <= '0;
            ofs_reg   <= '0;
            sum_reg   <= '0;
            bad_reg   <= '0;
            clr_reg   <= '0;
            op_reg    <= OP_STEP;
            last_reg  <= 1'b1;
        end
        else
        begin
            layout_reg <= layout_next;
            pend_reg   <= pend_next;
            wr_reg     <= wr_next;
            zero_reg   <= zero_next;
            phase_reg  <= phase_next;
            sel_reg    <= sel_next;
            ptr_reg    <= ptr_next;
            chk_reg    <= chk_next;
            base_reg   <= base_next;
            ofs_reg    <= ofs_next;
            sum_reg    <= sum_next;
            bad_reg    <= bad_next;
            clr_reg    <= clr_next;
            op_reg     <= op_next;
            last_reg   <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rbyte_reg  <= rbyte_next;
        sbyte_reg  <= sbyte_next;
        saddr_reg  <= saddr_next;
        sdata_reg  <= sdata_next;
        sctl_reg   <= sctl_next;
        raddr_reg  <= raddr_next;
        rdata_reg  <= rdata_next;
        rwrite_reg <= rwrite_next;
    end

    // result and status outputs
    assign storage_addr    = saddr_reg;
    assign storage_data    = sdata_reg;
    assign storage_ctl     = sctl_reg;
    assign ram_addr        = raddr_reg;
    assign ram_data        = rdata_reg;
    assign ram_write       = rwrite_reg;
    assign last            = last_reg;
    assign next_ram_addr   = cur_ram_addr;
    assign busy_res        = (phase_reg != PH_IDLE);
    assign status.last_res = last_reg;

endmodule

`default_nettype wire
